/* hdl/psa_pkg.sv */
// Shared types, constants and helpers for the projection sum aggregator.
// Used by psa_gather, psa_table and projection_sum_aggregator_unit; no dependencies.
package psa_pkg;

	localparam int OUT_BITS = 12;
	localparam int KEY_BITS = 64;
	localparam int MASK_W   = 64;
	localparam int VAL_W    = 64;
	localparam int RES_IDX_W = 12;

	localparam int IDX_W = OUT_BITS;
	localparam int DEPTH = 1 << OUT_BITS;
	localparam int POS_W = $clog2(MASK_W);
	localparam int CNT_W = $clog2(OUT_BITS + 1);

	localparam logic [MASK_W-1:0] KEY_MASK = {MASK_W{1'b1}} >> (MASK_W - KEY_BITS);

	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic                    operation;
		logic [MASK_W-1:0]       row_key;
		logic signed [VAL_W-1:0] row_value;
	} psa_in_t;

	typedef struct packed {
		logic [RES_IDX_W-1:0]    entry_index;
		logic signed [VAL_W-1:0] entry_sum;
	} psa_out_t;

	// Table request handed from the gather stage to the read-modify-write stage.
	typedef struct packed {
		logic             valid;
		logic             op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
	} psa_req_t;

	typedef enum logic {
		SCAN_IDLE,
		SCAN_RUN
	} psa_scan_state_t;

	typedef enum logic {
		TBL_CLEAR,
		TBL_RUN
	} psa_tbl_state_t;

	function automatic logic [RES_IDX_W-1:0] psa_res_index(input logic [IDX_W-1:0] idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[RES_IDX_W-1:0];
	endfunction

endpackage

/* hdl/psa_gather.sv */
// Select mask register, position scan and bit gather for the table index.
// Depends on psa_pkg.
module psa_gather
	import psa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MASK_W-1:0] cfg_data,
	input  logic [MASK_W-1:0] key,
	output logic [IDX_W-1:0]  idx,
	output logic              scan_busy
);

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MASK_W - 1);

	psa_scan_state_t   state_q, state_d;
	logic [MASK_W-1:0] mask_q;
	logic [POS_W-1:0]  scan_cnt_q;
	logic [CNT_W-1:0]  taken_q;
	logic [POS_W-1:0]  pos_q [OUT_BITS];
	logic [MASK_W-1:0] key_m;
	logic              take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		scan_busy = 1'b0;
		case (state_q)
			SCAN_IDLE: begin
				if (cfg_we) state_d = SCAN_RUN;
			end
			SCAN_RUN: begin
				scan_busy = 1'b1;
				if (cfg_we) state_d = SCAN_RUN;
				else if (scan_cnt_q == POS_LAST) state_d = SCAN_IDLE;
			end
			default: state_d = SCAN_IDLE;
		endcase
	end

	assign take = (state_q == SCAN_RUN) && mask_q[scan_cnt_q] && (taken_q < CNT_W'(OUT_BITS));

	// One mask bit is examined per cycle; the n-th set bit records its position in slot n.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= '0;
			taken_q    <= '0;
			scan_cnt_q <= '0;
		end else if (cfg_we) begin
			mask_q     <= cfg_data;
			taken_q    <= '0;
			scan_cnt_q <= '0;
		end else if (state_q == SCAN_RUN) begin
			scan_cnt_q <= scan_cnt_q + 1'b1;
			if (take) taken_q <= taken_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < OUT_BITS; i++) begin
			if (take && (taken_q == CNT_W'(i))) pos_q[i] <= scan_cnt_q;
		end
	end

	assign key_m = key & KEY_MASK;

	always_comb begin
		for (int i = 0; i < OUT_BITS; i++) begin
			idx[i] = (CNT_W'(i) < taken_q) ? key_m[pos_q[i]] : 1'b0;
		end
	end

	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (taken_q <= CNT_W'(OUT_BITS)) && (taken_q == $past(taken_q) + 1'b1))
		else $error("gather slot count ran past its bound");

endmodule

/* hdl/psa_table.sv */
// Sum table memory with clearing pass, read-modify-write and write forwarding.
// Depends on psa_pkg.
module psa_table
	import psa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  psa_req_t req,
	output logic     res_valid,
	output psa_out_t res,
	output logic     clear_busy
);

	psa_tbl_state_t   state_q, state_d;
	logic [IDX_W-1:0] clr_cnt_q;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_q;

	logic             v_s2;
	logic             op_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [VAL_W-1:0] val_s2;

	logic             fwd_v_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic [VAL_W-1:0] fwd_data_q;

	logic             res_valid_q;
	psa_out_t         res_q;

	logic [VAL_W-1:0] old_sum;
	logic [VAL_W-1:0] new_sum;
	logic             we;
	logic [IDX_W-1:0] wa;
	logic [VAL_W-1:0] wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TBL_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		clear_busy = 1'b0;
		case (state_q)
			TBL_CLEAR: begin
				clear_busy = 1'b1;
				if (clr_cnt_q == '1) state_d = TBL_RUN;
			end
			TBL_RUN: state_d = TBL_RUN;
			default: state_d = TBL_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (state_q == TBL_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// The entry written in the previous cycle is newer than what the memory returned.
	assign old_sum = (fwd_v_q && (fwd_idx_q == idx_s2)) ? fwd_data_q : rd_q;
	assign new_sum = (op_s2 == OP_ACCUM) ? old_sum + val_s2 : '0;

	assign we = clear_busy || v_s2;
	assign wa = clear_busy ? clr_cnt_q : idx_s2;
	assign wd = clear_busy ? '0 : new_sum;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (req.valid) rd_q <= mem[req.idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			fwd_v_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s2        <= req.valid;
			fwd_v_q     <= v_s2;
			res_valid_q <= v_s2 && (op_s2 == OP_READ);
		end
	end

	always_ff @(posedge clk) begin
		op_s2      <= req.op;
		idx_s2     <= req.idx;
		val_s2     <= req.value;
		fwd_idx_q  <= idx_s2;
		fwd_data_q <= new_sum;
		res_q.entry_index <= psa_res_index(idx_s2);
		res_q.entry_sum   <= old_sum;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TBL_CLEAR) |-> !v_s2 && !req.valid)
		else $error("table access during clearing pass");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $past(v_s2) && ($past(op_s2) == OP_READ))
		else $error("result strobe without a read beat");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (op_s2 == OP_READ)) |-> we && (wa == idx_s2) && (wd == '0))
		else $error("read beat did not clear its entry");

endmodule

/* hdl/projection_sum_aggregator_unit.sv */
// Top level of the projection sum aggregator: handshake, gather stage, table.
// Depends on psa_pkg, psa_gather and psa_table.

// Takes one beat per clock while busy is low: an accumulate adds row_value to the
// entry addressed by the row_key bits picked out by the select mask, and a read
// returns the sum of the entry addressed by the low IDX_W bits of row_key, not
// through the mask, and clears it. A read passes the input register and the table's
// read-modify-write stage, then its result is registered and shown for exactly one
// cycle with done high. The receiver cannot stall and must take it then. Results
// come in the order of the reads. Repeated indices in consecutive beats are handled
// by forwarding the last write, so the read-modify-write over the single table
// memory sets the rate of one beat per cycle. After reset, busy stays high while a
// clearing pass zeroes the table, one entry per cycle. After each write of the select
// mask, busy stays high while the mask is scanned one bit per cycle.
module projection_sum_aggregator_unit
	import psa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MASK_W-1:0] cfg_data,
	input  logic              start,
	output logic              busy,
	input  psa_in_t           item,
	output logic              done,
	output psa_out_t          result
);

	logic             scan_busy;
	logic             clear_busy;
	logic             accept;

	logic             v_s1;
	logic             op_s1;
	logic [MASK_W-1:0] key_s1;
	logic [VAL_W-1:0] val_s1;

	logic [IDX_W-1:0] gather_idx;
	psa_req_t         req;

	assign busy   = scan_busy || clear_busy;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= item.operation;
		key_s1 <= item.row_key;
		val_s1 <= item.row_value;
	end

	psa_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.key       (key_s1),
		.idx       (gather_idx),
		.scan_busy (scan_busy)
	);

	always_comb begin
		req.valid = v_s1;
		req.op    = op_s1;
		req.idx   = (op_s1 == OP_READ) ? key_s1[IDX_W-1:0] : gather_idx;
		req.value = val_s1;
	end

	psa_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.res_valid  (done),
		.res        (result),
		.clear_busy (clear_busy)
	);

endmodule

/* dv/psa_read_checker.sv */
// Checker for the projection sum aggregator: mirrors the sum table, predicts each read beat
// and compares it with the result strobed on done. Depends on psa_pkg for types and widths.
module psa_read_checker
	import psa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MASK_W-1:0] cfg_data,
	input  logic              start,
	input  logic              busy,
	input  psa_in_t           item,
	input  logic              done,
	input  psa_out_t          result,
	output int                fail_count,
	output int                open_reads
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PEND_DEPTH = 16;

	logic [MASK_W-1:0] kept_bits;
	logic [VAL_W-1:0]  sum_mirror [DEPTH];
	psa_out_t          want_fifo [PEND_DEPTH];
	int                wr_ptr = 0;
	int                rd_ptr = 0;
	int                fails = 0;

	// Packs the selected key bits, lowest selected position first, keeping only OUT_BITS of them.
	function automatic logic [IDX_W-1:0] gather_index(input logic [MASK_W-1:0] key,
			input logic [MASK_W-1:0] sel);
		logic [IDX_W-1:0] idx_bits;
		int taken;
		idx_bits = '0;
		taken = 0;
		key = key & KEY_MASK;
		for (int pos = 0; pos < MASK_W; pos++) begin
			if (sel[pos]) begin
				if (taken < OUT_BITS) begin
					idx_bits[taken] = key[pos];
				end
				taken++;
			end
		end
		return idx_bits;
	endfunction

	assign fail_count = fails;
	assign open_reads = wr_ptr - rd_ptr;

	always @(posedge clk or negedge arst_n) begin
		psa_out_t want;
		logic [IDX_W-1:0] idx;
		if (!arst_n) begin
			kept_bits = '0;
			for (int i = 0; i < DEPTH; i++) begin
				sum_mirror[i] = '0;
			end
			wr_ptr = 0;
			rd_ptr = 0;
		end else begin
			if (done) begin
				if (wr_ptr == rd_ptr) begin
					$error("result with no read waiting: entry_index %0d, entry_sum %0d",
						result.entry_index, result.entry_sum);
					fails++;
				end else begin
					want = want_fifo[rd_ptr % PEND_DEPTH];
					rd_ptr++;
					if (result.entry_index !== want.entry_index) begin
						$error("entry_index mismatch: expected %0d, actual %0d",
							want.entry_index, result.entry_index);
						fails++;
					end
					if (result.entry_sum !== want.entry_sum) begin
						$error("entry_sum mismatch: expected %0d, actual %0d",
							want.entry_sum, result.entry_sum);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				kept_bits = cfg_data;
			end
			if (start && !busy) begin
				if (item.operation == OP_ACCUM) begin
					idx = gather_index(item.row_key, kept_bits);
					sum_mirror[idx] = sum_mirror[idx] + item.row_value;
				end else begin
					idx = item.row_key[IDX_W-1:0];
					want.entry_index = RES_IDX_W'(idx);
					want.entry_sum = sum_mirror[idx];
					sum_mirror[idx] = '0;
					if (wr_ptr - rd_ptr >= PEND_DEPTH) begin
						$error("too many reads waiting: entry_index %0d", want.entry_index);
						fails++;
					end else begin
						want_fifo[wr_ptr % PEND_DEPTH] = want;
						wr_ptr++;
					end
				end
			end
		end
	end

endmodule

/* dv/projection_sum_aggregator_unit_test.sv */
// Testbench top for projection_sum_aggregator_unit: clock, reset, mask settings and beats.
// Depends on psa_pkg, the block and psa_read_checker, which does all prediction and comparison.
module projection_sum_aggregator_unit_test;
	import psa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES        = 10;
	localparam int PHASE_BEATS   = 113;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              cfg_we   = 1'b0;
	logic [MASK_W-1:0] cfg_data = '0;
	logic              start    = 1'b0;
	psa_in_t           item     = '0;
	logic              busy;
	logic              done;
	psa_out_t          result;
	int                fail_count;
	int                open_reads;
	int                stall_cycles = 0;
	logic              idle_on = 1'b1;
	int                span = 0;
	logic [MASK_W-1:0] key_pool [8];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	projection_sum_aggregator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result)
	);

	psa_read_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.open_reads (open_reads)
	);

	// The limit covers the clearing pass after reset with a wide margin.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("projection_sum_aggregator_unit regression: fail");
			$finish;
		end
	end

	task automatic send_beat(input logic op, input logic [MASK_W-1:0] key,
			input logic [VAL_W-1:0] val);
		psa_in_t beat;
		beat.operation = op;
		beat.row_key = key;
		beat.row_value = val;
		if (idle_on && $urandom_range(99) < 31) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 31);
		end
		start <= 1'b1;
		item <= beat;
		do @(posedge clk); while (busy);
	endtask

	// The mask is only changed once all reads are back and any accumulate has drained.
	task automatic set_mask(input logic [MASK_W-1:0] m);
		start <= 1'b0;
		while (open_reads != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		span = ($countones(m) < OUT_BITS) ? $countones(m) : OUT_BITS;
		for (int i = 0; i < 8; i++) begin
			key_pool[i] = {$urandom(), $urandom()};
		end
	endtask

	// Accumulates lean on a small key pool and reads on the populated index range,
	// so that sums build up and repeated indices come in close succession.
	task automatic random_beat();
		logic [MASK_W-1:0] key;
		logic [VAL_W-1:0] val;
		int pick;
		int small_val;
		key = {$urandom(), $urandom()};
		val = {$urandom(), $urandom()};
		pick = $urandom_range(99);
		if (pick < 8) begin
			val = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (pick < 16) begin
			val = {1'b1, {(VAL_W-1){1'b0}}};
		end else if (pick < 40) begin
			small_val = int'($urandom_range(20)) - 10;
			val = VAL_W'(small_val);
		end
		pick = $urandom_range(99);
		if ($urandom_range(99) < 30) begin
			if (pick < 40) begin
				key[IDX_W-1:0] = IDX_W'($urandom_range((1 << span) - 1));
			end else if (pick < 70) begin
				key[IDX_W-1:0] = key_pool[$urandom_range(7)][IDX_W-1:0];
			end
			send_beat(OP_READ, key, val);
		end else begin
			if (pick < 55) begin
				key = key_pool[$urandom_range(7)];
			end
			send_beat(OP_ACCUM, key, val);
		end
	endtask

	initial begin
		logic [MASK_W-1:0] masks [PHASES];
		masks[0] = '0;
		masks[1] = '1;
		masks[2] = 64'h0000_0000_0000_0FFF;
		masks[3] = 64'hFFF0_0000_0000_0000;
		masks[4] = {$urandom(), $urandom()} & {$urandom(), $urandom()} & {$urandom(), $urandom()};
		masks[5] = 64'h5555_5555_5555_5555;
		masks[6] = {$urandom(), $urandom()} & {$urandom(), $urandom()};
		masks[7] = 64'h8000_0000_0000_0007;
		masks[8] = {$urandom(), $urandom()};
		masks[9] = {$urandom(), $urandom()} & {$urandom(), $urandom()} & {$urandom(), $urandom()};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);

		// Reset mask is empty, so every accumulate lands in entry zero.
		send_beat(OP_READ, '0, {$urandom(), $urandom()});
		send_beat(OP_ACCUM, '1, {1'b0, {(VAL_W-1){1'b1}}});
		send_beat(OP_ACCUM, '0, 64'd1);
		send_beat(OP_READ, 64'hFFFF_FFFF_FFFF_F000, '1);
		send_beat(OP_ACCUM, {$urandom(), $urandom()}, {1'b1, {(VAL_W-1){1'b0}}});
		send_beat(OP_ACCUM, {$urandom(), $urandom()}, {1'b1, {(VAL_W-1){1'b0}}});
		send_beat(OP_READ, '0, '0);

		// More selected bits than index bits: only the lowest twelve count.
		set_mask('1);
		send_beat(OP_ACCUM, '1, '1);
		send_beat(OP_ACCUM, '1, 64'd5);
		send_beat(OP_READ, 64'h0000_0000_0000_0FFF, {$urandom(), $urandom()});
		send_beat(OP_READ, 64'h0000_0000_0000_0FFF, '0);
		send_beat(OP_ACCUM, 64'hFFFF_FFFF_FFFF_F123, 64'd42);
		send_beat(OP_READ, 64'h0000_0000_0000_0123, '0);
		send_beat(OP_READ, 64'hABCD_0000_0000_0123, '0);

		set_mask(64'h8000_0000_0000_0001);
		send_beat(OP_ACCUM, 64'h8000_0000_0000_0000, 64'd7);
		send_beat(OP_ACCUM, 64'h0000_0000_0000_0001, 64'd3);
		send_beat(OP_ACCUM, '1, -64'sd2);
		send_beat(OP_READ, 64'd2, '0);
		send_beat(OP_READ, 64'd1, '0);
		send_beat(OP_READ, 64'd3, '0);

		for (int p = 0; p < PHASES; p++) begin
			set_mask(masks[p]);
			idle_on = (p != 4);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				random_beat();
			end
		end
		idle_on = 1'b1;

		start <= 1'b0;
		while (open_reads != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0 && open_reads == 0) begin
			$display("projection_sum_aggregator_unit regression: pass");
		end else begin
			$display("projection_sum_aggregator_unit regression: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/psa_pkg.sv
hdl/psa_gather.sv
hdl/psa_table.sv
hdl/projection_sum_aggregator_unit.sv
dv/psa_read_checker.sv
dv/projection_sum_aggregator_unit_test.sv
